/* hw/rtl/mms_pkg.sv */
// mms_pkg: shared types and constants of the multimap store.
// Depends on nothing; every other file of the block but mms_if imports it.
package mms_pkg;

  localparam int KEY_W   = 32;
  localparam int VAL_W   = 32;
  localparam int PAIR_W  = KEY_W + VAL_W;
  localparam int ENTRY_W = 7;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_SEARCH = 2'd1,
    OP_REMOVE = 2'd2,
    OP_MAX    = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2,
    ST_EMPTY     = 2'd3
  } status_t;

  // One result transaction as built by the controller.
  typedef struct packed {
    status_t                   status;
    logic signed [VAL_W-1:0]   found_value;
    logic signed [KEY_W-1:0]   max_key;
    logic [ENTRY_W-1:0]        entry_count;
    logic                      last;
  } res_t;

endpackage

/* hw/rtl/mms_if.sv */
// mms_in_if / mms_out_if: valid/ready channels of the multimap store.
// Plain logic payloads; no package dependency.
interface mms_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         opcode;
  logic signed [31:0] key;
  logic signed [31:0] value;

  modport source (output valid, output opcode, output key, output value, input ready);
  modport sink   (input valid, input opcode, input key, input value, output ready);
endinterface

interface mms_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic signed [31:0] found_value;
  logic signed [31:0] max_key;
  logic [6:0]         entry_count;
  logic               last;

  modport source (output valid, output status, output found_value, output max_key,
                  output entry_count, output last, input ready);
  modport sink   (input valid, input status, input found_value, input max_key,
                  input entry_count, input last, output ready);
endinterface

/* hw/rtl/multimap_store.sv */
// multimap_store: top level of the key-to-many-values store.
// Depends on mms_pkg, mms_if, mms_mem and mms_ctrl.
//
// Stores up to CAPACITY signed 32-bit key/value pairs in insertion order in
// one single-port-read, single-port-write memory with a registered read.
// Opcodes: insert (duplicates allowed), search (every value under the key,
// newest first, last set on the final one, or one not-found transaction),
// remove one exact key/value pair (later entries slide down one slot), and
// largest key (empty status on an empty store). Insert into a full store
// leaves it unchanged and reports full. Every result transaction carries
// the pair count after the operation. One item is in work at a time.
// Insert, and anything on an empty store, go straight to the result. Largest
// key, search and a missing remove scan every stored pair, newest first;
// search also waits while the result channel stalls. A remove that hits at
// slot h scans down to h and then moves the entries above it down a slot.
// Any item also waits in S_DONE while the previous result still holds the
// output register. The scans and moves are paced by the one memory read per
// cycle, held while a search waits on the result channel.
// The result sits in an output register, so the next item is taken while
// the previous result still waits on out_ch. No clearing pass after reset:
// only slots below the count are ever read.
module multimap_store #(
  parameter int CAPACITY = 64
) (
  input  logic      clk,
  input  logic      rst_n,
  mms_in_if.sink    in_ch,
  mms_out_if.source out_ch
);
  import mms_pkg::*;

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);

  logic              mem_we, mem_re;
  logic [AW-1:0]     mem_waddr, mem_raddr;
  logic [PAIR_W-1:0] mem_wdata, mem_rdata;

  logic res_push, out_free;
  res_t res;

  // output register
  logic out_v_r, out_v_nxt;
  res_t out_res_r;

  mms_mem #(
    .DEPTH (CAPACITY),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  mms_ctrl #(
    .CAPACITY (CAPACITY),
    .AW       (AW),
    .CW       (CW)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .in_op     (op_t'(in_ch.opcode)),
    .in_key    (in_ch.key),
    .in_value  (in_ch.value),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_re    (mem_re),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata),
    .out_free  (out_free),
    .res_push  (res_push),
    .res       (res)
  );

  // slot is free when empty or being drained this cycle
  assign out_free  = !out_v_r || out_ch.ready;
  assign out_v_nxt = res_push ? 1'b1 : (out_ch.ready ? 1'b0 : out_v_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else begin
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_push) begin
      out_res_r <= res;
    end
  end

  assign out_ch.valid       = out_v_r;
  assign out_ch.status      = out_res_r.status;
  assign out_ch.found_value = out_res_r.found_value;
  assign out_ch.max_key     = out_res_r.max_key;
  assign out_ch.entry_count = out_res_r.entry_count;
  assign out_ch.last        = out_res_r.last;

endmodule

/* hw/rtl/mms_mem.sv */
// mms_mem: pair storage, one write port and one registered read port.
// Read data holds while the read enable is low. Uses mms_pkg widths.
module mms_mem #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic                      clk,
  input  logic                      we,
  input  logic [AW-1:0]             waddr,
  input  logic [mms_pkg::PAIR_W-1:0] wdata,
  input  logic                      re,
  input  logic [AW-1:0]             raddr,
  output logic [mms_pkg::PAIR_W-1:0] rdata
);
  import mms_pkg::*;

  logic [PAIR_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* hw/rtl/mms_ctrl.sv */
// mms_ctrl: sequencer of the multimap store; scans, compacts and builds results.
// Depends on mms_pkg; drives the mms_mem ports.
module mms_ctrl #(
  parameter int CAPACITY = 64,
  parameter int AW       = 6,
  parameter int CW       = 7
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  mms_pkg::op_t                in_op,
  input  logic signed [mms_pkg::KEY_W-1:0] in_key,
  input  logic signed [mms_pkg::VAL_W-1:0] in_value,
  output logic                        mem_we,
  output logic [AW-1:0]               mem_waddr,
  output logic [mms_pkg::PAIR_W-1:0]  mem_wdata,
  output logic                        mem_re,
  output logic [AW-1:0]               mem_raddr,
  input  logic [mms_pkg::PAIR_W-1:0]  mem_rdata,
  input  logic                        out_free,
  output logic                        res_push,
  output mms_pkg::res_t               res
);
  import mms_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_SCAN  = 4'b0010,
    S_SHIFT = 4'b0100,
    S_DONE  = 4'b1000
  } state_t;

  state_t                  state_r, state_nxt;
  op_t                     op_r, op_nxt;
  status_t                 status_r, status_nxt;
  logic signed [KEY_W-1:0] key_r, key_nxt;
  logic signed [VAL_W-1:0] val_r, val_nxt;
  logic [CW-1:0]           cnt_r, cnt_nxt;
  logic [CW-1:0]           idx_r, idx_nxt;   // scan: entries left; shift: next read
  logic                    rd_v_r, rd_v_nxt;
  logic [AW-1:0]           rd_addr_r, rd_addr_nxt;
  logic                    pend_v_r, pend_v_nxt;
  logic signed [VAL_W-1:0] pend_r, pend_nxt;  // held match, or running max key

  logic signed [KEY_W-1:0] rd_key;
  logic signed [VAL_W-1:0] rd_val;
  logic                    key_hit, pair_hit, stall;
  logic [CW-1:0]           idx_dec;

  assign rd_key   = mem_rdata[PAIR_W-1:VAL_W];
  assign rd_val   = mem_rdata[VAL_W-1:0];
  assign key_hit  = rd_v_r && (rd_key == key_r);
  assign pair_hit = key_hit && (rd_val == val_r);
  assign idx_dec  = idx_r - CW'(1);
  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt   = state_r;
    op_nxt      = op_r;
    status_nxt  = status_r;
    key_nxt     = key_r;
    val_nxt     = val_r;
    cnt_nxt     = cnt_r;
    idx_nxt     = idx_r;
    rd_v_nxt    = rd_v_r;
    rd_addr_nxt = rd_addr_r;
    pend_v_nxt  = pend_v_r;
    pend_nxt    = pend_r;
    stall       = 1'b0;
    mem_we      = 1'b0;
    mem_waddr   = '0;
    mem_wdata   = '0;
    mem_re      = 1'b0;
    mem_raddr   = '0;
    res_push    = 1'b0;
    res.status      = ST_OK;
    res.found_value = '0;
    res.max_key     = '0;
    res.entry_count = ENTRY_W'(cnt_r);
    res.last        = 1'b1;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          op_nxt     = in_op;
          key_nxt    = in_key;
          val_nxt    = in_value;
          pend_v_nxt = 1'b0;
          rd_v_nxt   = 1'b0;
          idx_nxt    = cnt_r;
          if (in_op == OP_INSERT) begin
            state_nxt = S_DONE;
            if (cnt_r == CW'(CAPACITY)) begin
              status_nxt = ST_FULL;
            end else begin
              mem_we     = 1'b1;
              mem_waddr  = cnt_r[AW-1:0];
              mem_wdata  = {in_key, in_value};
              cnt_nxt    = cnt_r + CW'(1);
              status_nxt = ST_OK;
            end
          end else if (cnt_r == '0) begin
            state_nxt  = S_DONE;
            status_nxt = (in_op == OP_MAX) ? ST_EMPTY : ST_NOT_FOUND;
          end else begin
            state_nxt = S_SCAN;
          end
        end
      end

      S_SCAN: begin
        // A second search hit releases the held one, not marked last.
        if (op_r == OP_SEARCH && key_hit && pend_v_r) begin
          if (out_free) begin
            res_push        = 1'b1;
            res.found_value = pend_r;
            res.last        = 1'b0;
          end else begin
            stall = 1'b1;
          end
        end
        if (op_r == OP_REMOVE && pair_hit) begin
          // hole found; the scan stops here and no read is marked valid
          rd_v_nxt  = 1'b0;
          idx_nxt   = CW'(rd_addr_r) + CW'(1);
          state_nxt = S_SHIFT;
        end else if (!stall) begin
          if (op_r == OP_SEARCH && key_hit) begin
            pend_v_nxt = 1'b1;
            pend_nxt   = rd_val;
          end
          if (op_r == OP_MAX && rd_v_r && (!pend_v_r || rd_key > pend_r)) begin
            pend_v_nxt = 1'b1;
            pend_nxt   = rd_key;
          end
          if (idx_r != '0) begin
            mem_re      = 1'b1;
            mem_raddr   = idx_dec[AW-1:0];
            rd_addr_nxt = idx_dec[AW-1:0];
            idx_nxt     = idx_dec;
            rd_v_nxt    = 1'b1;
          end else begin
            rd_v_nxt = 1'b0;
            if (!rd_v_r) begin
              state_nxt  = S_DONE;
              status_nxt = ((op_r == OP_SEARCH && !pend_v_r) || op_r == OP_REMOVE) ?
                           ST_NOT_FOUND : ST_OK;
            end
          end
        end
      end

      S_SHIFT: begin
        if (rd_v_r) begin
          mem_we    = 1'b1;
          mem_waddr = rd_addr_r - AW'(1);
          mem_wdata = mem_rdata;
        end
        if (idx_r < cnt_r) begin
          mem_re      = 1'b1;
          mem_raddr   = idx_r[AW-1:0];
          rd_addr_nxt = idx_r[AW-1:0];
          idx_nxt     = idx_r + CW'(1);
          rd_v_nxt    = 1'b1;
        end else begin
          rd_v_nxt = 1'b0;
          if (!rd_v_r) begin
            cnt_nxt    = cnt_r - CW'(1);
            status_nxt = ST_OK;
            state_nxt  = S_DONE;
          end
        end
      end

      S_DONE: begin
        if (out_free) begin
          res_push   = 1'b1;
          res.status = status_r;
          if (status_r == ST_OK && op_r == OP_SEARCH) res.found_value = pend_r;
          if (status_r == ST_OK && op_r == OP_MAX) res.max_key = pend_r;
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      cnt_r    <= '0;
      rd_v_r   <= 1'b0;
      pend_v_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      cnt_r    <= cnt_nxt;
      rd_v_r   <= rd_v_nxt;
      pend_v_r <= pend_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r      <= op_nxt;
    status_r  <= status_nxt;
    key_r     <= key_nxt;
    val_r     <= val_nxt;
    idx_r     <= idx_nxt;
    rd_addr_r <= rd_addr_nxt;
    pend_r    <= pend_nxt;
  end

endmodule

/* hw/rtl/mms_chk.sv */
// mms_chk: port-level checks on the multimap store result channel.
// Depends on mms_pkg; bound to multimap_store below.
module mms_chk #(
  parameter int CAPACITY = 64
) (
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_ready,
  input logic [1:0]         out_status,
  input logic signed [31:0] out_found_value,
  input logic signed [31:0] out_max_key,
  input logic [6:0]         out_entry_count,
  input logic               out_last
);
  import mms_pkg::*;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_entry_count <= ENTRY_W'(CAPACITY))
    else $error("entry count above capacity");

  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_FULL |-> out_entry_count == ENTRY_W'(CAPACITY))
    else $error("full reported below capacity");

  a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_EMPTY |-> out_entry_count == '0)
    else $error("empty reported with pairs stored");

  a_fail_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_OK |->
      out_last && out_found_value == '0 && out_max_key == '0)
    else $error("failure result not final or carries data");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status) &&
      $stable(out_found_value) && $stable(out_max_key) &&
      $stable(out_entry_count) && $stable(out_last))
    else $error("stalled result transaction changed");

endmodule

bind multimap_store mms_chk #(.CAPACITY(CAPACITY)) u_mms_chk (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .out_status      (out_ch.status),
  .out_found_value (out_ch.found_value),
  .out_max_key     (out_ch.max_key),
  .out_entry_count (out_ch.entry_count),
  .out_last        (out_ch.last)
);

/* tb/tb_top.sv */
`timescale 1ns / 100ps
// tb_top: self-checking testbench of multimap_store, a signed key/value multimap.
// Depends on mms_pkg and mms_if in hw/rtl and on the multimap_store RTL itself.
module tb_top;
  import mms_pkg::*;

  localparam int CAPACITY   = 64;
  localparam int MAX_CYCLES = 1_000_000;
  // Room for a remove that hits the oldest slot of a full store.
  localparam int TAIL_CYCLES = 2 * CAPACITY + 72;

  localparam logic signed [31:0] KEY_MIN  = 32'sh8000_0000;
  localparam logic signed [31:0] KEY_MAX  = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] FILL_KEY = -32'sd5;

  // One store operation waiting to be sent.
  typedef struct packed {
    op_t                op;
    logic signed [31:0] key;
    logic signed [31:0] value;
  } store_cmd_t;

  logic clk = 1'b0;
  logic rst_n;

  mms_in_if  in_ch ();
  mms_out_if out_ch ();

  multimap_store #(.CAPACITY(CAPACITY)) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Operations not yet sent, and the results the store still owes us.
  store_cmd_t store_cmds[$];
  res_t       awaited_results[$];

  // Predictor state: pairs in insertion order, index 0 oldest.
  logic signed [31:0] model_keys[$];
  logic signed [31:0] model_vals[$];

  // Pairs as the stimulus generator expects them once everything queued is
  // applied; used to aim searches and removes at pairs that are really stored.
  logic signed [31:0] plan_keys[$];
  logic signed [31:0] plan_vals[$];

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int mismatches    = 0;
  int cycle_count   = 0;

  // ---------------------------------------------------------------------------
  // Predictor: applies one accepted operation to the model and queues every
  // result transaction it must produce.
  // ---------------------------------------------------------------------------
  task automatic predict_store_op(input op_t op, input logic signed [31:0] k,
                                  input logic signed [31:0] v);
    res_t               r;
    int                 i;
    int                 hits;
    int                 sent;
    int                 slot;
    logic signed [31:0] top;
    r      = '0;
    r.last = 1'b1;
    case (op)
      OP_INSERT: begin
        if (model_keys.size() >= CAPACITY) begin
          r.status = ST_FULL;
        end else begin
          model_keys = {model_keys, k};
          model_vals = {model_vals, v};
          r.status = ST_OK;
        end
        r.entry_count = 7'(model_keys.size());
        awaited_results = {awaited_results, r};
      end
      OP_SEARCH: begin
        hits = 0;
        for (i = 0; i < model_keys.size(); i++)
          if (model_keys[i] == k) hits++;
        r.entry_count = 7'(model_keys.size());
        if (hits == 0) begin
          r.status = ST_NOT_FOUND;
          awaited_results = {awaited_results, r};
        end else begin
          // newest first; only the final one carries last
          sent = 0;
          for (i = model_keys.size() - 1; i >= 0; i--) begin
            if (model_keys[i] == k) begin
              sent++;
              r.status      = ST_OK;
              r.found_value = model_vals[i];
              r.last        = (sent == hits);
              awaited_results = {awaited_results, r};
            end
          end
        end
      end
      OP_REMOVE: begin
        // identical pairs cannot be told apart, so any matching slot will do
        slot = -1;
        for (i = model_keys.size() - 1; i >= 0 && slot < 0; i--)
          if (model_keys[i] == k && model_vals[i] == v) slot = i;
        if (slot < 0) begin
          r.status = ST_NOT_FOUND;
        end else begin
          model_keys.delete(slot);
          model_vals.delete(slot);
          r.status = ST_OK;
        end
        r.entry_count = 7'(model_keys.size());
        awaited_results = {awaited_results, r};
      end
      OP_MAX: begin
        if (model_keys.size() == 0) begin
          r.status = ST_EMPTY;
        end else begin
          top = model_keys[0];
          for (i = 1; i < model_keys.size(); i++)
            if (model_keys[i] > top) top = model_keys[i];
          r.status  = ST_OK;
          r.max_key = top;
        end
        r.entry_count = 7'(model_keys.size());
        awaited_results = {awaited_results, r};
      end
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic queue_cmd(input op_t op, input logic signed [31:0] k,
                           input logic signed [31:0] v);
    store_cmd_t c;
    int         i;
    bit         gone;
    c.op    = op;
    c.key   = k;
    c.value = v;
    store_cmds = {store_cmds, c};
    if (op == OP_INSERT && plan_keys.size() < CAPACITY) begin
      plan_keys = {plan_keys, k};
      plan_vals = {plan_vals, v};
    end else if (op == OP_REMOVE) begin
      gone = 1'b0;
      for (i = plan_keys.size() - 1; i >= 0 && !gone; i--) begin
        if (plan_keys[i] == k && plan_vals[i] == v) begin
          plan_keys.delete(i);
          plan_vals.delete(i);
          gone = 1'b1;
        end
      end
    end
  endtask

  // Mostly a small pool with the extremes, so keys and pairs repeat often.
  function automatic logic signed [31:0] pick_word();
    case ($urandom_range(0, 9))
      0:       return KEY_MIN;
      1:       return KEY_MAX;
      2:       return 32'sd0;
      3:       return -32'sd1;
      4, 5:    return 32'sd17;
      6:       return -32'sd17;
      default: return $urandom;
    endcase
  endfunction

  // Random mix, mostly aimed at stored pairs; ins_pct steers the fill level.
  task automatic queue_random(input int count, input int ins_pct);
    int                 n;
    int                 r;
    int                 idx;
    logic signed [31:0] k;
    logic signed [31:0] v;
    for (n = 0; n < count; n++) begin
      r = $urandom_range(0, 99);
      if (r < ins_pct) begin
        queue_cmd(OP_INSERT, pick_word(), pick_word());
      end else begin
        r = $urandom_range(0, 99);
        if (r < 40) begin
          if (plan_keys.size() > 0 && $urandom_range(0, 3) != 0)
            k = plan_keys[$urandom_range(0, plan_keys.size() - 1)];
          else
            k = pick_word();
          queue_cmd(OP_SEARCH, k, $urandom);
        end else if (r < 85) begin
          if (plan_keys.size() > 0 && $urandom_range(0, 99) < 70) begin
            idx = $urandom_range(0, plan_keys.size() - 1);
            k   = plan_keys[idx];
            v   = plan_vals[idx];
            // near miss: right key, one value bit off
            if ($urandom_range(0, 4) == 0) v = v ^ (32'h1 << $urandom_range(0, 31));
          end else begin
            k = $urandom;
            v = $urandom;
          end
          queue_cmd(OP_REMOVE, k, v);
        end else begin
          queue_cmd(OP_MAX, $urandom, $urandom);
        end
      end
    end
  endtask

  // Holds the sender until every queued operation has been answered.
  task automatic wait_drained();
    do @(negedge clk);
    while (store_cmds.size() != 0 || in_ch.valid || awaited_results.size() != 0);
  endtask

  task automatic check_field(input string what, input logic [31:0] want_v,
                             input logic [31:0] got_v);
    if (want_v !== got_v) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %h, got %h", $time, what, want_v, got_v);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Driver: presents queued operations, idling at random. The item on the
  // channel at a rising edge with ready high is the accepted transaction and
  // goes to the predictor right there, in acceptance order.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : drive_cmds
    store_cmd_t nxt;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready)
        predict_store_op(op_t'(in_ch.opcode), in_ch.key, in_ch.value);
      if (!in_ch.valid || in_ch.ready) begin
        if (store_cmds.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          nxt = store_cmds.pop_front();
          in_ch.valid  <= 1'b1;
          in_ch.opcode <= nxt.op;
          in_ch.key    <= nxt.key;
          in_ch.value  <= nxt.value;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: stalls the result channel at random and checks each transaction
  // against the oldest awaited result.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : check_results
    res_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (awaited_results.size() == 0) begin
          mismatches++;
          $display("%0t: result with nothing awaited, status %0d count %0d",
                   $time, out_ch.status, out_ch.entry_count);
        end else begin
          want = awaited_results.pop_front();
          check_field("status",      32'(want.status),      32'(out_ch.status));
          check_field("found_value", want.found_value,      out_ch.found_value);
          check_field("max_key",     want.max_key,          out_ch.max_key);
          check_field("entry_count", 32'(want.entry_count), 32'(out_ch.entry_count));
          check_field("last",        32'(want.last),        32'(out_ch.last));
        end
      end
      out_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // Watchdog: a hung handshake ends the run here.
  initial begin
    while (cycle_count < MAX_CYCLES) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("tb_top: FAIL");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Sequence: reset, then three phases with different idling. Each phase is
  // drained completely before the next starts, which also gives the sender a
  // pause that lets the store go fully idle.
  // ---------------------------------------------------------------------------
  initial begin
    rst_n         = 1'b0;
    in_ch.valid   = 1'b0;
    in_ch.opcode  = OP_INSERT;
    in_ch.key     = '0;
    in_ch.value   = '0;
    out_ch.ready  = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // phase 1: sender idles often, receiver idles most of the time
    send_idle_pct = 35;
    recv_idle_pct = 79;

    // empty-store corner cases; the unused fields carry junk on purpose
    queue_cmd(OP_MAX,    32'sd9,  32'sd3);
    queue_cmd(OP_SEARCH, 32'sd9,  -32'sd1);
    queue_cmd(OP_REMOVE, 32'sd9,  32'sd3);
    // extremes of key and value, a duplicate key and an identical pair
    queue_cmd(OP_INSERT, KEY_MIN, KEY_MAX);
    queue_cmd(OP_INSERT, KEY_MAX, KEY_MIN);
    queue_cmd(OP_INSERT, 32'sd0,  32'sd0);
    queue_cmd(OP_INSERT, KEY_MAX, -32'sd1);
    queue_cmd(OP_INSERT, KEY_MAX, -32'sd1);
    queue_cmd(OP_SEARCH, KEY_MAX, 32'sd0);   // three values, newest first
    queue_cmd(OP_SEARCH, 32'sd5,  32'sd0);   // no match
    queue_cmd(OP_MAX,    32'sd0,  KEY_MAX);
    queue_cmd(OP_REMOVE, KEY_MAX, -32'sd1);  // one of two identical pairs
    queue_cmd(OP_REMOVE, KEY_MAX, 32'sd7);   // key matches, value does not
    queue_cmd(OP_REMOVE, KEY_MIN, KEY_MIN);  // same
    queue_cmd(OP_SEARCH, KEY_MAX, KEY_MIN);
    queue_cmd(OP_REMOVE, KEY_MAX, KEY_MIN);  // newer entries slide down
    queue_cmd(OP_REMOVE, KEY_MAX, -32'sd1);
    queue_cmd(OP_MAX,    KEY_MAX, 32'sd0);   // zero over the most negative key
    queue_cmd(OP_REMOVE, 32'sd0,  32'sd0);
    queue_cmd(OP_MAX,    32'sd1,  32'sd1);   // only a negative key left
    queue_cmd(OP_SEARCH, KEY_MIN, 32'sd123);
    queue_cmd(OP_REMOVE, KEY_MIN, KEY_MAX);  // back to empty
    queue_cmd(OP_MAX,    -32'sd1, -32'sd1);

    // fill to capacity under one key, overflow, then a search that hits all
    while (plan_keys.size() < CAPACITY) queue_cmd(OP_INSERT, FILL_KEY, $urandom);
    queue_cmd(OP_INSERT, 32'sd1, 32'sd1);
    queue_cmd(OP_INSERT, FILL_KEY, 32'sd2);
    queue_cmd(OP_SEARCH, FILL_KEY, 32'sd0);
    queue_cmd(OP_MAX,    32'sd0, 32'sd0);
    queue_cmd(OP_SEARCH, 32'sd1, 32'sd0);
    queue_random(110, 25);
    wait_drained();

    // phase 2: roles swapped
    send_idle_pct = 79;
    recv_idle_pct = 35;
    queue_random(135, 50);
    wait_drained();

    // phase 3: back-to-back on both sides
    send_idle_pct = 0;
    recv_idle_pct = 0;
    queue_random(135, 45);
    wait_drained();

    // anything the store emits now is a stray result
    repeat (TAIL_CYCLES) @(negedge clk);
    if (mismatches == 0 && awaited_results.size() == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule
